// ===== sv/stuffed_frame_receiver_unit_macros.svh =====
// Assertion macros shared by the stuffed frame receiver RTL.
`ifndef STUFFED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stuffed frame receiver assertion failed");

// Check a consequence in the cycle after its antecedent.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stuffed frame receiver assertion failed");

`endif

// ===== sv/sfr_pkg.sv =====
// Package: constants and types of the stuffed frame receiver.
package sfr_pkg;

    localparam int MAX_FRAME_BYTES_DEFAULT = 2048;
    localparam int LENGTH_W = 12;
    localparam int CFG_INDEX_W = 4;

    localparam logic [7:0] FLAG_BYTE = 8'h5C;
    localparam logic [7:0] ESC_BYTE = 8'h5D;
    localparam logic [7:0] ESC_FLAG = 8'h7C;
    localparam logic [7:0] ESC_ESC = 8'h7D;
    localparam logic [7:0] CTL_RR = 8'h01;
    localparam logic [7:0] CTL_REJ = 8'h05;
    localparam logic [7:0] SEQ_TX = 8'h02;
    localparam logic [7:0] SEQ_RX = 8'h20;

    localparam logic [7:0] ADDRESS_RESET = 8'h01;
    localparam logic [7:0] MAX_REJECTS_RESET = 8'h03;

    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_BYTE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_REJECTS = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_RR = 2'd1,
        KIND_REJ = 2'd2,
        KIND_GAVE_UP = 2'd3
    } kind_t;

endpackage

// ===== sv/sfr_if.sv =====
// Interfaces: line byte, result and configuration channels.
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink (input valid, input line_byte, output ready);
endinterface

interface sfr_result_if;
    import sfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [7:0]          data_byte;
    logic [7:0]          reply_control;
    logic [LENGTH_W-1:0] data_length;

    modport source (output valid, output kind, output data_byte, output reply_control,
                    output data_length, input ready);
    modport sink (input valid, input kind, input data_byte, input reply_control,
                  input data_length, output ready);
endinterface

interface sfr_cfg_if;
    import sfr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [7:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/stuffed_frame_receiver_unit.sv =====
// A line byte is captured in the input register, decoded, and its result loaded into the result register.
// Throughput: one line byte per cycle, set by the single decode pass between the
// input register and the result register; a stalled result holds one byte in the
// input register. Reset (rst_n low, asynchronous) initialises every register: hunting
// for a flag, expected sequence 0, reply sequence 1, address 0x01, max_rejects 3.
module stuffed_frame_receiver_unit #(
    parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    sfr_byte_if.sink        rx,
    sfr_result_if.source    res,
    sfr_cfg_if.sink         cfg
);
    import sfr_pkg::*;

    // Saturation point of the payload count, limited by the 12-bit length field.
    localparam int CountLimitInt = (MAX_FRAME_BYTES < 4095) ? MAX_FRAME_BYTES : 4095;
    localparam logic [LENGTH_W-1:0] CountLimit = LENGTH_W'(CountLimitInt);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // Configuration registers.
    logic [7:0] address_reg;
    logic [7:0] max_rejects_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Receiver state and its next values.
    phase_t              phase_reg, phase_next;
    logic                expected_seq_reg, expected_seq_next;
    logic                reply_seq_reg, reply_seq_next;
    logic [7:0]          check_reg, check_next;
    logic                escape_reg, escape_next;
    logic [7:0]          held_symbol_reg, held_symbol_next;
    logic                held_valid_reg, held_valid_next;
    logic [7:0]          reject_count_reg, reject_count_next;
    logic [LENGTH_W-1:0] payload_count_reg, payload_count_next;

    // Result register.
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [7:0]          out_data_reg;
    logic [7:0]          out_ctl_reg;
    logic [LENGTH_W-1:0] out_len_reg;

    // Result of the current decode pass.
    logic                res_valid;
    kind_t               res_kind;
    logic [7:0]          res_data;
    logic [7:0]          res_ctl;
    logic [LENGTH_W-1:0] res_len;

    logic       proc_go;
    logic       rx_ready;
    logic       out_free;
    logic [7:0] ctl_byte;
    logic [7:0] rseq_byte;
    logic       sym_valid;
    logic [7:0] sym;
    logic [7:0] reject_inc;
    logic       rel_valid;
    logic [7:0] rel_sym;
    logic       take_plain;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || res.ready;
    // Decode the held byte whenever its result has somewhere to go.
    assign proc_go  = in_valid_reg && out_free;
    // Take a new byte when the input register is empty or is being consumed.
    assign rx_ready = !in_valid_reg || proc_go;
    assign rx.ready = rx_ready;
    assign cfg.ready = 1'b1;

    assign res.valid         = out_valid_reg;
    assign res.kind          = out_kind_reg;
    assign res.data_byte     = out_data_reg;
    assign res.reply_control = out_ctl_reg;
    assign res.data_length   = out_len_reg;

    // Single decode pass over one line byte.
    always_comb
    begin
        phase_next         = phase_reg;
        expected_seq_next  = expected_seq_reg;
        reply_seq_next     = reply_seq_reg;
        check_next         = check_reg;
        escape_next        = escape_reg;
        held_symbol_next   = held_symbol_reg;
        held_valid_next    = held_valid_reg;
        reject_count_next  = reject_count_reg;
        payload_count_next = payload_count_reg;

        res_valid = 1'b0;
        res_kind  = KIND_DATA;
        res_data  = 8'h00;
        res_ctl   = 8'h00;
        res_len   = '0;

        ctl_byte   = expected_seq_reg ? SEQ_TX : 8'h00;
        rseq_byte  = reply_seq_reg ? SEQ_RX : 8'h00;
        sym_valid  = held_valid_reg || escape_reg;
        sym        = escape_reg ? ESC_BYTE : held_symbol_reg;
        reject_inc = (reject_count_reg == 8'hFF) ? 8'hFF : reject_count_reg + 8'd1;
        rel_valid  = held_valid_reg;
        rel_sym    = held_symbol_reg;
        take_plain = 1'b1;

        case (phase_reg)
            PH_FLAG:
            begin
                // The match test wins over the flag test.
                if (in_byte_reg == address_reg)
                    phase_next = PH_ADDR;
                else
                    phase_next = (in_byte_reg == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
            end
            PH_ADDR:
            begin
                if (in_byte_reg == ctl_byte)
                    phase_next = PH_CTRL;
                else
                    phase_next = (in_byte_reg == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
            end
            PH_CTRL:
            begin
                if (in_byte_reg == (address_reg ^ ctl_byte))
                begin
                    // Header complete: start a fresh payload.
                    phase_next         = PH_DATA;
                    check_next         = 8'h00;
                    escape_next        = 1'b0;
                    held_symbol_next   = 8'h00;
                    held_valid_next    = 1'b0;
                    payload_count_next = '0;
                end
                else
                begin
                    phase_next = (in_byte_reg == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
                end
            end
            PH_DATA:
            begin
                if (in_byte_reg == FLAG_BYTE)
                begin
                    // Closing flag: the last symbol (a dangling escape counts) is BCC2.
                    phase_next      = PH_HUNT;
                    escape_next     = 1'b0;
                    held_valid_next = 1'b0;
                    res_valid       = 1'b1;
                    if (sym_valid && (sym == check_reg))
                    begin
                        res_kind          = KIND_RR;
                        res_ctl           = CTL_RR ^ rseq_byte;
                        res_len           = payload_count_reg;
                        expected_seq_next = !expected_seq_reg;
                        reply_seq_next    = !reply_seq_reg;
                        reject_count_next = 8'h00;
                    end
                    else if (reject_inc >= max_rejects_reg)
                    begin
                        res_kind          = KIND_GAVE_UP;
                        res_ctl           = CTL_REJ ^ rseq_byte;
                        reject_count_next = 8'h00;
                    end
                    else
                    begin
                        res_kind          = KIND_REJ;
                        res_ctl           = CTL_REJ ^ rseq_byte;
                        reject_count_next = reject_inc;
                    end
                end
                else
                begin
                    // Resolve a pending escape first.
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                        if (in_byte_reg == ESC_FLAG)
                        begin
                            held_symbol_next = FLAG_BYTE;
                            held_valid_next  = 1'b1;
                            take_plain       = 1'b0;
                        end
                        else if (in_byte_reg == ESC_ESC)
                        begin
                            held_symbol_next = ESC_BYTE;
                            held_valid_next  = 1'b1;
                            take_plain       = 1'b0;
                        end
                        else
                        begin
                            // Pass the escape byte through; this byte stands alone.
                            rel_valid = 1'b1;
                            rel_sym   = ESC_BYTE;
                        end
                    end
                    if (take_plain)
                    begin
                        if (rel_valid)
                        begin
                            res_valid  = 1'b1;
                            res_kind   = KIND_DATA;
                            res_data   = rel_sym;
                            check_next = check_reg ^ rel_sym;
                            if (payload_count_reg < CountLimit)
                                payload_count_next = payload_count_reg + LENGTH_W'(1);
                        end
                        held_valid_next = 1'b0;
                        if (in_byte_reg == ESC_BYTE)
                        begin
                            escape_next = 1'b1;
                        end
                        else
                        begin
                            held_symbol_next = in_byte_reg;
                            held_valid_next  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = (in_byte_reg == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
            end
        endcase
    end

    // State, input register, result register and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg       <= ADDRESS_RESET;
            max_rejects_reg   <= MAX_REJECTS_RESET;
            in_valid_reg      <= 1'b0;
            in_byte_reg       <= 8'h00;
            phase_reg         <= PH_HUNT;
            expected_seq_reg  <= 1'b0;
            reply_seq_reg     <= 1'b1;
            check_reg         <= 8'h00;
            escape_reg        <= 1'b0;
            held_symbol_reg   <= 8'h00;
            held_valid_reg    <= 1'b0;
            reject_count_reg  <= 8'h00;
            payload_count_reg <= '0;
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= KIND_DATA;
            out_data_reg      <= 8'h00;
            out_ctl_reg       <= 8'h00;
            out_len_reg       <= '0;
        end
        else
        begin
            // Write a register on a configuration transaction; drop unknown indexes.
            if (cfg.valid)
            begin
                if (cfg.index == REG_ADDRESS_BYTE)
                    address_reg <= cfg.data;
                else if (cfg.index == REG_MAX_REJECTS)
                    max_rejects_reg <= cfg.data;
            end

            // Hold the line byte until it is decoded.
            if (rx_ready)
            begin
                in_valid_reg <= rx.valid;
                if (rx.valid)
                    in_byte_reg <= rx.line_byte;
            end

            // Advance the receiver on every decode pass.
            if (proc_go)
            begin
                phase_reg         <= phase_next;
                expected_seq_reg  <= expected_seq_next;
                reply_seq_reg     <= reply_seq_next;
                check_reg         <= check_next;
                escape_reg        <= escape_next;
                held_symbol_reg   <= held_symbol_next;
                held_valid_reg    <= held_valid_next;
                reject_count_reg  <= reject_count_next;
                payload_count_reg <= payload_count_next;
            end

            // Load the result register when it is free.
            if (out_free)
                out_valid_reg <= proc_go && res_valid;
            if (proc_go && res_valid)
            begin
                out_kind_reg <= res_kind;
                out_data_reg <= res_data;
                out_ctl_reg  <= res_ctl;
                out_len_reg  <= res_len;
            end
        end
    end

`include "stuffed_frame_receiver_unit_macros.svh"

    // A give-up result leaves the reject count cleared.
    `SFR_ASSERT_NOW(a_gave_up_clears, clk, rst_n, out_valid_reg && (out_kind_reg == KIND_GAVE_UP), reject_count_reg == 8'h00)
    // A payload byte is only ever shown while the receiver is inside a frame.
    `SFR_ASSERT_NOW(a_data_in_frame, clk, rst_n, out_valid_reg && (out_kind_reg == KIND_DATA), phase_reg == PH_DATA)
    // A held symbol and a pending escape never coexist.
    `SFR_ASSERT_NOW(a_held_xor_escape, clk, rst_n, held_valid_reg, !escape_reg)
    // Back-pressure on the line side only comes from a stalled, full pipeline.
    `SFR_ASSERT_NOW(a_stall_cause, clk, rst_n, !rx_ready, in_valid_reg && out_valid_reg && !res.ready)
    // A stalled decode leaves the receiver state untouched.
    `SFR_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_valid_reg && !proc_go, phase_reg == $past(phase_reg))

endmodule
